// ===== design/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types, constants and helpers for the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int SEQ_SPACE_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int SEQ_BITS  = 3;
  localparam int WORD_BITS = 64;
  localparam int CFG_BITS  = 3;

  localparam logic [CFG_BITS-1:0] WIN_MIN      = 3'd1;
  localparam logic [CFG_BITS-1:0] WIN_MAX      = 3'd4;
  localparam logic [CFG_BITS-1:0] WIN_RESET    = 3'd3;
  localparam logic [2:0]          MAX_RUN      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_DELIVER,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic capture;
    logic store;
    logic deliver;
    logic ack;
  } cmd_t;

  typedef struct packed {
    logic good;
    logic do_store;
    logic is_base;
    logic next_held;
  } status_t;

  // Out-of-range window sizes saturate into the legal range.
  function automatic logic [CFG_BITS-1:0] win_eff(input logic [CFG_BITS-1:0] w);
    logic [CFG_BITS-1:0] r;
    r = w;
    if (w < WIN_MIN) r = WIN_MIN;
    if (w > WIN_MAX) r = WIN_MAX;
    return r;
  endfunction

endpackage

// ===== design/selective_repeat_receiver.sv =====
// Sequence: a bad-checksum item is dropped in the cycle after acceptance (ST_EVAL);
// otherwise ST_EVAL leads to ST_ACK, through ST_READ and ST_DELIVER when deliveries are due.
// A new item is accepted only in ST_IDLE, once the sequencer has finished the last one;
// the payload store has a single read port.
// Reset: window_size 3, window base 1, held flags cleared; no clearing pass.
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Selective repeat ARQ receiver: stores in-window packets, delivers in order,
// and sends a cumulative acknowledgement for each good packet.
// ----------------------------------------------------------------------------
module selective_repeat_receiver #(
  parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [srr_pkg::SEQ_BITS-1:0]  seq_number,
  input  logic [srr_pkg::WORD_BITS-1:0] payload_word,
  input  logic                          checksum_ok,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srr_pkg::CFG_BITS-1:0]  cfg_data,
  output logic                          strobe,
  output logic                          kind,
  output logic [srr_pkg::WORD_BITS-1:0] delivered_data,
  output logic [srr_pkg::SEQ_BITS-1:0]  ack_number,
  output logic                          last
);

  srr_pkg::cmd_t    cmd;
  srr_pkg::status_t sts;

  assign cfg_ready = !busy;

  srr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .strobe(strobe)
  );

  srr_datapath #(
    .SEQ_SPACE   (SEQ_SPACE),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .seq_number    (seq_number),
    .payload_word  (payload_word),
    .checksum_ok   (checksum_ok),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .delivered_data(delivered_data),
    .ack_number    (ack_number),
    .last          (last)
  );

endmodule

// ===== design/srr_ram.sv =====
// ----------------------------------------------------------------------------
// srr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/srr_datapath.sv =====
// ----------------------------------------------------------------------------
// srr_datapath
// Window base, held flags, payload store and result formatting.
// ----------------------------------------------------------------------------
module srr_datapath #(
  parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srr_pkg::cmd_t                 cmd,
  output srr_pkg::status_t              sts,
  input  logic [srr_pkg::SEQ_BITS-1:0]  seq_number,
  input  logic [srr_pkg::WORD_BITS-1:0] payload_word,
  input  logic                          checksum_ok,
  input  logic                          cfg_write,
  input  logic [srr_pkg::CFG_BITS-1:0]  cfg_data,
  output logic                          kind,
  output logic [srr_pkg::WORD_BITS-1:0] delivered_data,
  output logic [srr_pkg::SEQ_BITS-1:0]  ack_number,
  output logic                          last
);

  localparam int SW    = $clog2(SEQ_SPACE);
  localparam int CW    = ((SW > srr_pkg::SEQ_BITS) ? SW : srr_pkg::SEQ_BITS) + 1;
  localparam int WordW = srr_pkg::WORD_BITS;
  localparam int SeqW  = srr_pkg::SEQ_BITS;

  localparam logic [SW-1:0] BaseReset = SW'(1 % SEQ_SPACE);
  localparam logic [SW-1:0] BaseTop   = SW'(SEQ_SPACE - 1);
  localparam logic [CW-1:0] SpaceW    = CW'(SEQ_SPACE);

  logic [srr_pkg::CFG_BITS-1:0] window_size;
  logic [SW-1:0]                base;
  logic [SEQ_SPACE-1:0]         held;
  logic [SeqW-1:0]              seq_reg;
  logic [PAYLOAD_BITS-1:0]      payload_reg;
  logic                         ok_reg;

  logic [SW-1:0]           seq_idx;
  logic [SW-1:0]           base_inc;
  logic [SW-1:0]           base_prev;
  logic [CW-1:0]           seq_w;
  logic [CW-1:0]           base_w;
  logic [CW-1:0]           seq_off;
  logic                    seq_in;
  logic                    in_win;
  logic [SW-1:0]           raddr;
  logic [PAYLOAD_BITS-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= srr_pkg::WIN_RESET;
    end else if (cfg_write) begin
      window_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_reg     <= seq_number;
      payload_reg <= PAYLOAD_BITS'(payload_word);
      ok_reg      <= checksum_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BaseReset;
      held <= '0;
    end else begin
      if (cmd.store) begin
        held[seq_idx] <= 1'b1;
      end
      if (cmd.deliver) begin
        held[base] <= 1'b0;
        base       <= base_inc;
      end
    end
  end

  always_comb begin
    seq_idx   = SW'(seq_reg);
    base_inc  = (base == BaseTop) ? '0 : base + SW'(1);
    base_prev = (base == '0) ? BaseTop : base - SW'(1);
    seq_w     = CW'(seq_reg);
    base_w    = CW'(base);
    seq_in    = seq_w < SpaceW;
    seq_off   = (seq_w >= base_w) ? seq_w - base_w : seq_w + SpaceW - base_w;
    in_win    = seq_in && (seq_off < CW'(srr_pkg::win_eff(window_size)));
    // The first delivery reads the base; later ones prefetch the next slot.
    raddr     = cmd.deliver ? base_inc : base;
  end

  always_comb begin
    sts.good      = ok_reg;
    sts.do_store  = in_win && !held[seq_idx];
    sts.is_base   = seq_idx == base;
    sts.next_held = held[base_inc];
  end

  srr_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(SEQ_SPACE)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(seq_idx),
    .wdata(payload_reg),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign kind           = cmd.ack;
  assign last           = cmd.ack;
  assign ack_number     = cmd.ack ? SeqW'(base_prev) : '0;
  assign delivered_data = cmd.deliver ? WordW'(rdata) : '0;

endmodule

// ===== design/srr_ctrl.sv =====
// ----------------------------------------------------------------------------
// srr_ctrl
// Sequencer for one packet: evaluate, store, deliver the in-order run, ack; a bad-checksum packet is dropped.
// ----------------------------------------------------------------------------
module srr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  srr_pkg::status_t sts,
  output srr_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             strobe
);

  srr_pkg::state_t state;
  srr_pkg::state_t state_next;
  logic [2:0]      count;
  logic [2:0]      count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      srr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = srr_pkg::ST_EVAL;
        end
      end
      srr_pkg::ST_EVAL: begin
        if (!sts.good) begin
          state_next = srr_pkg::ST_IDLE;
        end else if (sts.do_store) begin
          cmd.store  = 1'b1;
          state_next = sts.is_base ? srr_pkg::ST_READ : srr_pkg::ST_ACK;
        end else begin
          state_next = srr_pkg::ST_ACK;
        end
      end
      srr_pkg::ST_READ: begin
        count_next = '0;
        state_next = srr_pkg::ST_DELIVER;
      end
      srr_pkg::ST_DELIVER: begin
        cmd.deliver = 1'b1;
        count_next  = count + 3'd1;
        if (sts.next_held && (count + 3'd1 < srr_pkg::MAX_RUN)) begin
          state_next = srr_pkg::ST_DELIVER;
        end else begin
          state_next = srr_pkg::ST_ACK;
        end
      end
      srr_pkg::ST_ACK: begin
        cmd.ack    = 1'b1;
        state_next = srr_pkg::ST_IDLE;
      end
      default: begin
        state_next = srr_pkg::ST_IDLE;
      end
    endcase
  end

  assign strobe = cmd.deliver || cmd.ack;

`ifndef SYNTH
  a_deliver_origin: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> ($past(state) == srr_pkg::ST_READ || $past(state) == srr_pkg::ST_DELIVER))
    else $error("delivery not preceded by a read");

  a_plain_ack: assert property (@(posedge clk) disable iff (rst)
    (state == srr_pkg::ST_EVAL && sts.good && !sts.do_store) |=> state == srr_pkg::ST_ACK)
    else $error("unstored good packet did not go to acknowledgement");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    state == srr_pkg::ST_DELIVER |-> count < srr_pkg::MAX_RUN)
    else $error("delivery run exceeded its cap");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(state) == srr_pkg::ST_ACK ||
                     ($past(state) == srr_pkg::ST_EVAL && !$past(sts.good))))
    else $error("item ended without an acknowledgement or a bad checksum");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the selective repeat receiver. Packets are sent
// through the start/busy handshake, a packet-level predictor works out the
// deliveries and the acknowledgement each good packet causes, and every strobed
// result is checked field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam int WORD_BITS = srr_pkg::WORD_BITS;
  localparam int SEQ_BITS  = srr_pkg::SEQ_BITS;
  localparam int CFG_BITS  = srr_pkg::CFG_BITS;
  localparam logic [CFG_BITS-1:0] WIN_MIN   = srr_pkg::WIN_MIN;
  localparam logic [CFG_BITS-1:0] WIN_MAX   = srr_pkg::WIN_MAX;
  localparam logic [CFG_BITS-1:0] WIN_RESET = srr_pkg::WIN_RESET;
  localparam logic [2:0]          MAX_RUN   = srr_pkg::MAX_RUN;

  typedef struct {
    logic                 kind;
    logic [WORD_BITS-1:0] data;
    logic [SEQ_BITS-1:0]  ack;
    logic                 last;
  } srr_result_t;

  // Packet-level model of the receive window and the results it produces.
  class srr_scoreboard;
    logic [CFG_BITS-1:0]  win_size;
    logic [SEQ_BITS-1:0]  base;
    bit                   held[8];
    logic [WORD_BITS-1:0] slot[8];
    srr_result_t          pending_results[$];
    int errors;
    int n_items;
    int n_dropped;
    int n_delivered;
    int n_acks;

    function new();
      win_size = WIN_RESET;
      base = SEQ_BITS'(1);
      foreach (held[i]) held[i] = 0;
      errors = 0;
      n_items = 0;
      n_dropped = 0;
      n_delivered = 0;
      n_acks = 0;
    endfunction

    function void set_window(logic [CFG_BITS-1:0] value);
      win_size = value;
    endfunction

    function int span();
      if (win_size < WIN_MIN) return int'(WIN_MIN);
      if (win_size > WIN_MAX) return int'(WIN_MAX);
      return int'(win_size);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void push_result(logic kind, logic [WORD_BITS-1:0] data,
                              logic [SEQ_BITS-1:0] ack, logic last);
      srr_result_t r;
      r.kind = kind;
      r.data = data;
      r.ack = ack;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function void note_item(logic [SEQ_BITS-1:0] seq, logic [WORD_BITS-1:0] word,
                            logic ok);
      logic [SEQ_BITS-1:0] offset;
      int run;
      n_items++;
      if (!ok) begin
        n_dropped++;
        return;
      end
      offset = seq - base;
      run = 0;
      if (int'(offset) < span() && !held[seq]) begin
        slot[seq] = word;
        held[seq] = 1;
        if (seq == base) begin
          while (held[base] && run < int'(MAX_RUN)) begin
            push_result(KIND_DELIVER, slot[base], '0, 1'b0);
            held[base] = 0;
            base = base + SEQ_BITS'(1);
            run++;
          end
        end
      end
      n_delivered += run;
      n_acks++;
      push_result(KIND_ACK, '0, base - SEQ_BITS'(1), 1'b1);
    endfunction

    function void check_result(logic kind, logic [WORD_BITS-1:0] data,
                               logic [SEQ_BITS-1:0] ack, logic last);
      srr_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0b data=%h ack=%0d last=%0b",
                 $time, kind, data, ack, last);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (kind !== exp_r.kind) begin
        $display("%0t: kind mismatch, expected %0b, actual %0b", $time, exp_r.kind, kind);
        errors++;
      end
      if (data !== exp_r.data) begin
        $display("%0t: delivered_data mismatch, expected %h, actual %h",
                 $time, exp_r.data, data);
        errors++;
      end
      if (ack !== exp_r.ack) begin
        $display("%0t: ack_number mismatch, expected %0d, actual %0d", $time, exp_r.ack, ack);
        errors++;
      end
      if (last !== exp_r.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [SEQ_BITS-1:0]  seq_number = '0;
  logic [WORD_BITS-1:0] payload_word = '0;
  logic                 checksum_ok = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_BITS-1:0]  cfg_data = '0;
  logic                 strobe;
  logic                 kind;
  logic [WORD_BITS-1:0] delivered_data;
  logic [SEQ_BITS-1:0]  ack_number;
  logic                 last;

  srr_scoreboard sb = new();
  int sender_idle_pct = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  selective_repeat_receiver uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .seq_number(seq_number),
    .payload_word(payload_word),
    .checksum_ok(checksum_ok),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .kind(kind),
    .delivered_data(delivered_data),
    .ack_number(ack_number),
    .last(last)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(kind, delivered_data, ack_number, last);
  end

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still pending",
               $time, STALL_LIMIT, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_packet(logic [SEQ_BITS-1:0] seq, logic [WORD_BITS-1:0] word,
                             logic ok);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    seq_number <= seq;
    payload_word <= word;
    checksum_ok <= ok;
    do @(posedge clk); while (busy);
    sb.note_item(seq, word, ok);
  endtask

  // Holds the sender off until every expected result is out and the block
  // has had time to drop a trailing bad-checksum item.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_BITS-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_window(value);
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_packet();
    logic [SEQ_BITS-1:0]  seq;
    logic [WORD_BITS-1:0] word;
    logic                 ok;
    int pick;
    pick = $urandom_range(0, 99);
    ok = 1'b1;
    if (pick < 65) begin
      // Somewhere inside the current window, in any order.
      seq = sb.base + SEQ_BITS'($urandom_range(0, sb.span() - 1));
    end else if (pick < 75) begin
      // Prefer a duplicate of a packet that is already held.
      seq = SEQ_BITS'($urandom_range(0, 7));
      for (int k = 0; k < 8; k++) begin
        if (sb.held[seq]) break;
        seq = seq + SEQ_BITS'(1);
      end
    end else if (pick < 88) begin
      seq = SEQ_BITS'($urandom_range(0, 7));
    end else begin
      seq = sb.base + SEQ_BITS'($urandom_range(0, 3));
      ok = 1'b0;
    end
    if ($urandom_range(0, 9) == 0) begin
      word = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      word = {$urandom, $urandom};
    end
    send_packet(seq, word, ok);
  endtask

  task automatic run_phase(int idle_pct, int count);
    sender_idle_pct = idle_pct;
    write_window(CFG_BITS'($urandom_range(0, 7)));
    for (int i = 0; i < count; i++) begin
      if (i > 0 && i % 45 == 0) write_window(CFG_BITS'($urandom_range(0, 7)));
      else if ($urandom_range(0, 49) == 0) drain();
      send_random_packet();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset window of 3 and base 1.
    send_packet(3'd1, 64'h0, 1'b1);
    send_packet(3'd3, '1, 1'b1);
    send_packet(3'd3, 64'h1234_5678_9abc_def0, 1'b1);
    send_packet(3'd2, 64'hdead_beef_0000_0001, 1'b0);
    send_packet(3'd5, 64'h0f0f_0f0f_0f0f_0f0f, 1'b1);
    send_packet(3'd2, 64'h5555_5555_5555_5555, 1'b1);
    send_packet(3'd7, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);

    // Widest window: three held packets released by the base, wrapping to 0.
    write_window(WIN_MAX);
    send_packet(3'd7, 64'h8000_0000_0000_0000, 1'b1);
    send_packet(3'd6, 64'h0000_0000_0000_0001, 1'b1);
    send_packet(3'd5, 64'hffff_0000_ffff_0000, 1'b1);
    send_packet(3'd4, 64'h0123_4567_89ab_cdef, 1'b1);

    // A size of zero acts as one.
    write_window('0);
    send_packet(3'd1, 64'h1111_1111_1111_1111, 1'b1);
    send_packet(3'd0, 64'h2222_2222_2222_2222, 1'b1);

    // Sizes above the maximum saturate.
    write_window('1);
    send_packet(3'd4, 64'h3333_3333_3333_3333, 1'b1);
    send_packet(3'd5, 64'h4444_4444_4444_4444, 1'b1);
    send_packet(3'd1, '1, 1'b1);

    write_window(WIN_MIN);
    send_packet(3'd2, 64'h0, 1'b1);

    run_phase(25, 135);
    run_phase(88, 135);
    run_phase(0, 135);

    drain();
    $display("Covered %0d packets (%0d with bad checksum) over %0d window settings.",
             sb.n_items, sb.n_dropped, cfg_writes + 1);
    $display("Checked %0d deliveries and %0d acknowledgements.", sb.n_delivered, sb.n_acks);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
